FILE: hw/rtl/ipv4_route_table_top_macros.svh
// Assertion macros shared by the route table checker
`ifndef IPV4_ROUTE_TABLE_TOP_MACROS_SVH
`define IPV4_ROUTE_TABLE_TOP_MACROS_SVH

// consequent in the clock after the antecedent
`define RT_ASSERT_NEXT(lbl, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("route table check failed");

// consequent in the same clock as the antecedent
`define RT_ASSERT_NOW(lbl, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("route table check failed");

`endif

FILE: hw/rtl/ipv4rt_pkg.sv
// Types, codes and constants of the IPv4 route table
`timescale 1ns / 1ps
`default_nettype none

package ipv4rt_pkg;

    localparam int TABLE_DEPTH_DEF = 64;
    localparam int IFACE_BITS      = 4;
    localparam int ADDR_W          = 32;
    localparam int FLAG_W          = 8;
    localparam int INDEX_W         = 6;
    localparam int REMOVED_W       = 7;

    localparam logic [FLAG_W-1:0] GW_MASK_RESET = 8'h02;

    typedef enum logic [1:0] {
        CMD_ADD          = 2'd0,
        CMD_LOOKUP_ADDR  = 2'd1,
        CMD_LOOKUP_IFACE = 2'd2,
        CMD_REMOVE       = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        STATUS_OK        = 2'd0,
        STATUS_NOT_FOUND = 2'd1,
        STATUS_FULL      = 2'd2
    } status_t;

    typedef struct packed {
        logic [ADDR_W-1:0]     dest;
        logic [ADDR_W-1:0]     gateway;
        logic [ADDR_W-1:0]     mask;
        logic [FLAG_W-1:0]     flags;
        logic [ADDR_W-1:0]     metric;
        logic [IFACE_BITS-1:0] iface;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    typedef struct packed {
        cmd_t                  cmd;
        logic [ADDR_W-1:0]     address;
        logic [ADDR_W-1:0]     gateway_addr;
        logic [ADDR_W-1:0]     net_mask;
        logic [FLAG_W-1:0]     flags;
        logic [ADDR_W-1:0]     cost;
        logic [IFACE_BITS-1:0] iface;
    } req_t;

    typedef struct packed {
        status_t                status;
        logic [INDEX_W-1:0]     index;
        entry_t                 entry;
        logic [REMOVED_W-1:0]   removed;
    } result_t;

    typedef struct packed {
        logic addr_hit;
        logic iface_hit;
        logic gw_flag;
    } match_t;

endpackage

`default_nettype wire

FILE: hw/rtl/ipv4rt_ram.sv
// Generic single-write, single-read RAM with registered read data
`timescale 1ns / 1ps
`default_nettype none

module ipv4rt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

FILE: hw/rtl/ipv4rt_match.sv
// Shared compare unit: tests one stored route against the command key
`timescale 1ns / 1ps
`default_nettype none

module ipv4rt_match import ipv4rt_pkg::*; (
    input  wire entry_t                  ent,
    input  wire logic [ADDR_W-1:0]       key_addr,
    input  wire logic [IFACE_BITS-1:0]   key_iface,
    input  wire logic [FLAG_W-1:0]       gw_mask,
    output match_t                       result
);

    always_comb
    begin
        result.addr_hit  = (key_addr & ent.mask) == (ent.dest & ent.mask);
        result.iface_hit = ent.iface == key_iface;
        result.gw_flag   = |(ent.flags & gw_mask);
    end

endmodule

`default_nettype wire

FILE: hw/rtl/ipv4rt_seq.sv
// Command sequencer: append, table scan, compaction and result register
`timescale 1ns / 1ps
`default_nettype none

module ipv4rt_seq import ipv4rt_pkg::*; #(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1
) (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    req_valid,
    output logic                         req_ready,
    input  wire req_t                    req,
    output logic                         res_valid,
    input  wire logic                    res_ready,
    output result_t                      res,
    output logic                         ram_we,
    output logic [AW-1:0]                ram_waddr,
    output entry_t                       ram_wdata,
    output logic                         ram_re,
    output logic [AW-1:0]                ram_raddr,
    input  wire entry_t                  ram_rdata,
    output logic [ADDR_W-1:0]            key_addr,
    output logic [IFACE_BITS-1:0]        key_iface,
    input  wire match_t                  mt
);

    localparam int CW = $clog2(TABLE_DEPTH + 1);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_SCAN = 3'b010,
        S_DONE = 3'b100
    } state_t;

    state_t                state_reg, state_next;
    logic [CW-1:0]         count_reg, count_next;
    logic [CW-1:0]         rd_ptr_reg, rd_ptr_next;
    logic                  dv_reg, dv_next;
    logic [CW-1:0]         keep_reg, keep_next;
    logic [CW-1:0]         removed_reg, removed_next;
    logic                  have_gw_reg, have_gw_next;
    logic                  out_valid_reg, out_valid_next;

    cmd_t                  cmd_reg, cmd_next;
    logic [ADDR_W-1:0]     addr_reg, addr_next;
    logic [IFACE_BITS-1:0] iface_reg, iface_next;
    logic [CW-1:0]         cmp_idx_reg, cmp_idx_next;
    logic [CW-1:0]         gw_idx_reg, gw_idx_next;
    entry_t                gw_ent_reg, gw_ent_next;
    result_t               pend_reg, pend_next;
    result_t               out_res_reg, out_res_next;

    logic   accept;
    logic   full;
    logic   scanning;
    logic   more;
    logic   hit_now;
    logic   issue;
    logic   scan_end;
    entry_t new_ent;

    assign req_ready = state_reg == S_IDLE;
    assign accept    = req_valid && req_ready;
    assign full      = count_reg == CW'(TABLE_DEPTH);
    assign scanning  = state_reg == S_SCAN;
    assign more      = rd_ptr_reg < count_reg;
    assign hit_now   = dv_reg
                       && ((cmd_reg == CMD_LOOKUP_ADDR && mt.addr_hit)
                           || (cmd_reg == CMD_LOOKUP_IFACE && mt.iface_hit));
    assign issue     = scanning && more && !hit_now;
    assign scan_end  = scanning && !dv_reg && !more;

    always_comb
    begin
        new_ent.dest    = req.address;
        new_ent.gateway = req.gateway_addr;
        new_ent.mask    = req.net_mask;
        new_ent.flags   = req.flags;
        new_ent.metric  = req.cost;
        new_ent.iface   = req.iface;
    end

    assign ram_re    = issue;
    assign ram_raddr = rd_ptr_reg[AW-1:0];
    assign ram_we    = (accept && req.cmd == CMD_ADD && !full)
                       || (scanning && dv_reg && cmd_reg == CMD_REMOVE && !mt.iface_hit);
    assign ram_waddr = accept ? count_reg[AW-1:0] : keep_reg[AW-1:0];
    assign ram_wdata = accept ? new_ent : ram_rdata;

    assign key_addr  = addr_reg;
    assign key_iface = iface_reg;

    assign res_valid = out_valid_reg;
    assign res       = out_res_reg;

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        rd_ptr_next    = rd_ptr_reg;
        dv_next        = issue;
        keep_next      = keep_reg;
        removed_next   = removed_reg;
        have_gw_next   = have_gw_reg;
        out_valid_next = out_valid_reg;
        cmd_next       = cmd_reg;
        addr_next      = addr_reg;
        iface_next     = iface_reg;
        cmp_idx_next   = issue ? rd_ptr_reg : cmp_idx_reg;
        gw_idx_next    = gw_idx_reg;
        gw_ent_next    = gw_ent_reg;
        pend_next      = pend_reg;
        out_res_next   = out_res_reg;

        if (res_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    cmd_next     = req.cmd;
                    addr_next    = req.address;
                    iface_next   = req.iface;
                    rd_ptr_next  = '0;
                    keep_next    = '0;
                    removed_next = '0;
                    have_gw_next = 1'b0;
                    pend_next    = '0;
                    if (req.cmd == CMD_ADD)
                    begin
                        if (full)
                        begin
                            pend_next.status = STATUS_FULL;
                        end
                        else
                        begin
                            pend_next.status = STATUS_OK;
                            pend_next.index  = INDEX_W'(count_reg);
                            pend_next.entry  = new_ent;
                            count_next       = count_reg + 1'b1;
                        end
                        state_next = S_DONE;
                    end
                    else
                    begin
                        state_next = S_SCAN;
                    end
                end
            end

            S_SCAN:
            begin
                if (issue)
                begin
                    rd_ptr_next = rd_ptr_reg + 1'b1;
                end
                if (dv_reg)
                begin
                    case (cmd_reg)
                        CMD_REMOVE:
                        begin
                            if (mt.iface_hit)
                            begin
                                removed_next = removed_reg + 1'b1;
                            end
                            else
                            begin
                                keep_next = keep_reg + 1'b1;
                            end
                        end
                        CMD_LOOKUP_ADDR:
                        begin
                            if (!mt.addr_hit && !have_gw_reg && mt.gw_flag)
                            begin
                                have_gw_next = 1'b1;
                                gw_idx_next  = cmp_idx_reg;
                                gw_ent_next  = ram_rdata;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
                if (hit_now)
                begin
                    pend_next        = '0;
                    pend_next.status = STATUS_OK;
                    pend_next.index  = INDEX_W'(cmp_idx_reg);
                    pend_next.entry  = ram_rdata;
                    state_next       = S_DONE;
                end
                else if (scan_end)
                begin
                    pend_next = '0;
                    case (cmd_reg)
                        CMD_REMOVE:
                        begin
                            count_next        = keep_reg;
                            pend_next.status  = STATUS_OK;
                            pend_next.removed = REMOVED_W'(removed_reg);
                        end
                        CMD_LOOKUP_ADDR:
                        begin
                            if (have_gw_reg)
                            begin
                                pend_next.status = STATUS_OK;
                                pend_next.index  = INDEX_W'(gw_idx_reg);
                                pend_next.entry  = gw_ent_reg;
                            end
                            else
                            begin
                                pend_next.status = STATUS_NOT_FOUND;
                            end
                        end
                        default:
                        begin
                            pend_next.status = STATUS_NOT_FOUND;
                        end
                    endcase
                    state_next = S_DONE;
                end
            end

            S_DONE:
            begin
                if (!out_valid_reg || res_ready)
                begin
                    out_valid_next = 1'b1;
                    out_res_next   = pend_reg;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            rd_ptr_reg    <= '0;
            dv_reg        <= 1'b0;
            keep_reg      <= '0;
            removed_reg   <= '0;
            have_gw_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            rd_ptr_reg    <= rd_ptr_next;
            dv_reg        <= dv_next;
            keep_reg      <= keep_next;
            removed_reg   <= removed_next;
            have_gw_reg   <= have_gw_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg     <= cmd_next;
        addr_reg    <= addr_next;
        iface_reg   <= iface_next;
        cmp_idx_reg <= cmp_idx_next;
        gw_idx_reg  <= gw_idx_next;
        gw_ent_reg  <= gw_ent_next;
        pend_reg    <= pend_next;
        out_res_reg <= out_res_next;
    end

endmodule

`default_nettype wire

FILE: hw/rtl/ipv4_route_table_top.sv
// Top level of the first-match IPv4 route table
//
//  Channel   Handshake              Beat
//  -------   ---------------------  ------------------------------------------
//  cfg       cfg_valid / cfg_ready  cfg_data: gateway flag mask
//  in        in_valid / in_ready    cmd, address, gateway_addr, net_mask,
//                                   route_flag_bits, route_cost, iface_id
//  out       out_valid / out_ready  status, hit_*, removed_count
//
//  Add: the result goes through the pending register into the output register.
//  Lookups and remove: one route per cycle through the single read port of the
//  route RAM; a lookup stops at its first hit.
//  One command at a time; in_ready is low from the in beat until the result
//  moves into the output register. cfg_ready is always high.
//  Reset clears the route count and sets the gateway mask to GW_MASK_RESET; the RAM needs no clearing.
`timescale 1ns / 1ps
`default_nettype none

module ipv4_route_table_top import ipv4rt_pkg::*; #(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    cfg_valid,
    output logic                         cfg_ready,
    input  wire logic [FLAG_W-1:0]       cfg_data,
    input  wire logic                    in_valid,
    output logic                         in_ready,
    input  wire logic [1:0]              cmd,
    input  wire logic [ADDR_W-1:0]       address,
    input  wire logic [ADDR_W-1:0]       gateway_addr,
    input  wire logic [ADDR_W-1:0]       net_mask,
    input  wire logic [FLAG_W-1:0]       route_flag_bits,
    input  wire logic [ADDR_W-1:0]       route_cost,
    input  wire logic [IFACE_BITS-1:0]   iface_id,
    output logic                         out_valid,
    input  wire logic                    out_ready,
    output logic [1:0]                   status,
    output logic [INDEX_W-1:0]           hit_index,
    output logic [ADDR_W-1:0]            hit_dest,
    output logic [ADDR_W-1:0]            hit_gateway,
    output logic [ADDR_W-1:0]            hit_mask,
    output logic [FLAG_W-1:0]            hit_flags,
    output logic [ADDR_W-1:0]            hit_metric,
    output logic [IFACE_BITS-1:0]        hit_iface,
    output logic [REMOVED_W-1:0]         removed_count
);

    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

    logic [FLAG_W-1:0]     gw_mask_reg;
    req_t                  req;
    result_t               res;
    logic                  ram_we;
    logic [AW-1:0]         ram_waddr;
    entry_t                ram_wdata;
    logic                  ram_re;
    logic [AW-1:0]         ram_raddr;
    entry_t                ram_rdata;
    logic [ADDR_W-1:0]     key_addr;
    logic [IFACE_BITS-1:0] key_iface;
    match_t                mt;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gw_mask_reg <= GW_MASK_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            gw_mask_reg <= cfg_data;
        end
    end

    always_comb
    begin
        req.cmd          = cmd_t'(cmd);
        req.address      = address;
        req.gateway_addr = gateway_addr;
        req.net_mask     = net_mask;
        req.flags        = route_flag_bits;
        req.cost         = route_cost;
        req.iface        = iface_id;
    end

    ipv4rt_seq #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (in_valid),
        .req_ready (in_ready),
        .req       (req),
        .res_valid (out_valid),
        .res_ready (out_ready),
        .res       (res),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_wdata (ram_wdata),
        .ram_re    (ram_re),
        .ram_raddr (ram_raddr),
        .ram_rdata (ram_rdata),
        .key_addr  (key_addr),
        .key_iface (key_iface),
        .mt        (mt)
    );

    ipv4rt_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    ipv4rt_match u_match (
        .ent       (ram_rdata),
        .key_addr  (key_addr),
        .key_iface (key_iface),
        .gw_mask   (gw_mask_reg),
        .result    (mt)
    );

    assign status        = res.status;
    assign hit_index     = res.index;
    assign hit_dest      = res.entry.dest;
    assign hit_gateway   = res.entry.gateway;
    assign hit_mask      = res.entry.mask;
    assign hit_flags     = res.entry.flags;
    assign hit_metric    = res.entry.metric;
    assign hit_iface     = res.entry.iface;
    assign removed_count = res.removed;

endmodule

`default_nettype wire

FILE: hw/rtl/ipv4rt_checker.sv
// Port-level checks of the route table, bound to the top level
`timescale 1ns / 1ps
`default_nettype none

`include "ipv4_route_table_top_macros.svh"

module ipv4rt_checker import ipv4rt_pkg::*; (
    input wire logic                  clk,
    input wire logic                  rst_n,
    input wire logic                  in_valid,
    input wire logic                  in_ready,
    input wire logic                  out_valid,
    input wire logic                  out_ready,
    input wire logic [1:0]            status,
    input wire logic [INDEX_W-1:0]    hit_index,
    input wire logic [ADDR_W-1:0]     hit_dest,
    input wire logic [REMOVED_W-1:0]  removed_count
);

    // result beat held while stalled
    `RT_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(status) && $stable(hit_index) && $stable(hit_dest) && $stable(removed_count))

    // one command at a time
    `RT_ASSERT_NEXT(a_busy_after_beat, in_valid && in_ready, !in_ready)

    // not found and full carry no route and no count
    `RT_ASSERT_NOW(a_miss_zero, out_valid && status != STATUS_OK, hit_index == '0 && hit_dest == '0 && removed_count == '0)

    // a removal count comes with no route
    `RT_ASSERT_NOW(a_remove_clean, out_valid && removed_count != '0, status == STATUS_OK && hit_index == '0 && hit_dest == '0)

endmodule

bind ipv4_route_table_top ipv4rt_checker u_checker (.*);

`default_nettype wire
